>>> rtl/fbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared widths, codes and beat types of the frustum box cull pipeline.
// ----------------------------------------------------------------------------
package fbc_pkg;

  localparam int MAX_PLANES = 6;
  localparam int NPTS       = 9;   // eight corners then the centre
  localparam int CENTRE     = 8;

  localparam int PW   = 48;  // rotation entry times local bound
  localparam int AW   = 53;  // world accumulator at 19 fraction bits
  localparam int WW   = 39;  // world coordinate at 5 fraction bits
  localparam int HW   = 33;  // absolute box extent
  localparam int R2W  = 68;  // squared radius
  localparam int PRW  = 51;  // normal part times world coordinate
  localparam int DW   = 54;  // plane distance
  localparam int SQW  = 106; // squared distance

  localparam logic [2:0] CFG_MODE   = 3'd0;
  localparam logic [2:0] CFG_COUNT  = 3'd1;
  localparam logic [2:0] CFG_PLANE0 = 3'd2;

  localparam logic [1:0] MODE_OFF = 2'd0;

  localparam logic [1:0] REASON_KEEP   = 2'd0;
  localparam logic [1:0] REASON_SPHERE = 2'd1;
  localparam logic [1:0] REASON_CORNER = 2'd2;

  typedef logic [WW-1:0] coord_t;
  typedef coord_t [2:0] point_t;

  typedef struct packed {
    logic                 vld;
    point_t [NPTS-1:0]    pts;
    logic [R2W-1:0]       r2;
    logic                 sph;
    logic                 cor;
  } beat_t;

endpackage

>>> rtl/frustum_box_cull_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_box_cull_top
// Frustum cull of a transformed box: sphere test then eight corner test.
// ----------------------------------------------------------------------------
// pipeline: 3 transform stages, 4 stages in each of the 6 plane cells and
//   1 output register lie between input beat and result beat
// throughput: one box per cycle while the skid stage is empty; the plane cells
//   form a chain that every beat walks through, and a skid stage keeps input open while one result waits
// reset: mode 2, six planes, all planes zero, pipeline empty
module frustum_box_cull_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [47:0]        rot_row0,
  input  logic [47:0]        rot_row1,
  input  logic [47:0]        rot_row2,
  input  logic signed [31:0] trans_x,
  input  logic signed [31:0] trans_y,
  input  logic signed [31:0] trans_z,
  input  logic signed [31:0] box_min_x,
  input  logic signed [31:0] box_min_y,
  input  logic signed [31:0] box_min_z,
  input  logic signed [31:0] box_max_x,
  input  logic signed [31:0] box_max_y,
  input  logic signed [31:0] box_max_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               culled,
  output logic [1:0]         cull_reason,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import fbc_pkg::*;

  logic [1:0]  mode;
  logic [2:0]  count;
  logic [63:0] planes [MAX_PLANES];
  logic [2:0]  n_sat;
  logic        full;
  logic        adv;
  beat_t       chain [MAX_PLANES+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= 2'd2;
      count <= 3'(MAX_PLANES);
      for (int i = 0; i < MAX_PLANES; i++) begin
        planes[i] <= '0;
      end
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MODE) begin
        mode <= cfg_data[1:0];
      end else if (cfg_index == CFG_COUNT) begin
        count <= cfg_data[2:0];
      end else begin
        planes[3'(cfg_index - CFG_PLANE0)] <= cfg_data;
      end
    end
  end

  assign n_sat    = (count > 3'(MAX_PLANES)) ? 3'(MAX_PLANES) : count;
  assign adv      = !full;
  assign in_stall = full;

  fbc_xform u_xform (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .take      (in_valid && !in_stall),
    .rot_row0  (rot_row0),
    .rot_row1  (rot_row1),
    .rot_row2  (rot_row2),
    .trans_x   (trans_x),
    .trans_y   (trans_y),
    .trans_z   (trans_z),
    .box_min_x (box_min_x),
    .box_min_y (box_min_y),
    .box_min_z (box_min_z),
    .box_max_x (box_max_x),
    .box_max_y (box_max_y),
    .box_max_z (box_max_z),
    .bout      (chain[0])
  );

  for (genvar g = 0; g < MAX_PLANES; g++) begin : g_cell
    fbc_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .adv    (adv),
      .plane  (planes[g]),
      .active (3'(g) < n_sat),
      .bin    (chain[g]),
      .bout   (chain[g+1])
    );
  end

  fbc_out u_out (
    .clk         (clk),
    .rst         (rst),
    .bin         (chain[MAX_PLANES]),
    .mode        (mode),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .culled      (culled),
    .cull_reason (cull_reason),
    .full        (full)
  );

endmodule

>>> rtl/fbc_xform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_xform
// Moves the box centre and corners to world space and forms the squared radius.
// ----------------------------------------------------------------------------
module fbc_xform (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  take,
  input  logic [47:0]           rot_row0,
  input  logic [47:0]           rot_row1,
  input  logic [47:0]           rot_row2,
  input  logic signed [31:0]    trans_x,
  input  logic signed [31:0]    trans_y,
  input  logic signed [31:0]    trans_z,
  input  logic signed [31:0]    box_min_x,
  input  logic signed [31:0]    box_min_y,
  input  logic signed [31:0]    box_min_z,
  input  logic signed [31:0]    box_max_x,
  input  logic signed [31:0]    box_max_y,
  input  logic signed [31:0]    box_max_z,
  output fbc_pkg::beat_t        bout
);
  import fbc_pkg::*;

  logic [47:0]           rows [3];
  logic signed [31:0]    bmn [3];
  logic signed [31:0]    bmx [3];
  logic signed [31:0]    trn [3];
  logic signed [15:0]    rc [3][3];
  logic signed [32:0]    diff [3];
  logic [HW-1:0]         hmag [3];

  // stage one
  logic                  v1;
  logic signed [PW-1:0]  pmin [3][3];
  logic signed [PW-1:0]  pmax [3][3];
  logic signed [31:0]    tr [3];
  logic [HW-1:0]         h [3];

  // stage two
  logic                  v2;
  point_t [NPTS-1:0]     pts2;
  point_t [NPTS-1:0]     pts_next;
  logic [31:0]           hh2 [3];
  logic [32:0]           hhl [3];
  logic [33:0]           hl2 [3];

  // stage three
  logic                  v3;
  point_t [NPTS-1:0]     pts3;
  logic [R2W-1:0]        r2;
  logic [R2W-1:0]        r2_next;

  assign rows[0] = rot_row0;
  assign rows[1] = rot_row1;
  assign rows[2] = rot_row2;
  assign bmn[0] = box_min_x;
  assign bmn[1] = box_min_y;
  assign bmn[2] = box_min_z;
  assign bmx[0] = box_max_x;
  assign bmx[1] = box_max_y;
  assign bmx[2] = box_max_z;
  assign trn[0] = trans_x;
  assign trn[1] = trans_y;
  assign trn[2] = trans_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rc[i][j] = rows[i][16*j +: 16];
      end
    end
    for (int j = 0; j < 3; j++) begin
      diff[j] = 33'(bmx[j]) - 33'(bmn[j]);
      hmag[j] = diff[j][32] ? HW'(-diff[j]) : HW'(diff[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pmin[i][j] <= PW'(rc[i][j]) * PW'(bmn[j]);
          pmax[i][j] <= PW'(rc[i][j]) * PW'(bmx[j]);
        end
        tr[i] <= trn[i];
        h[i]  <= hmag[i];
      end
    end
  end

  // corners use twice the chosen bound, the centre min plus max
  always_comb begin
    logic signed [AW-1:0] s;
    logic signed [AW-1:0] acc;
    for (int k = 0; k < 8; k++) begin
      for (int i = 0; i < 3; i++) begin
        s = '0;
        for (int j = 0; j < 3; j++) begin
          s = s + (((k >> j) & 1) != 0 ? AW'(pmax[i][j]) : AW'(pmin[i][j]));
        end
        acc = (s <<< 1) + (AW'(tr[i]) <<< 15);
        pts_next[k][i] = WW'(acc >>> 14);
      end
    end
    for (int i = 0; i < 3; i++) begin
      s = '0;
      for (int j = 0; j < 3; j++) begin
        s = s + AW'(pmin[i][j]) + AW'(pmax[i][j]);
      end
      acc = s + (AW'(tr[i]) <<< 15);
      pts_next[CENTRE][i] = WW'(acc >>> 14);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pts2 <= pts_next;
      for (int j = 0; j < 3; j++) begin
        hh2[j] <= 32'(h[j][32:17]) * 32'(h[j][32:17]);
        hhl[j] <= 33'(h[j][32:17]) * 33'(h[j][16:0]);
        hl2[j] <= 34'(h[j][16:0]) * 34'(h[j][16:0]);
      end
    end
  end

  always_comb begin
    r2_next = '0;
    for (int j = 0; j < 3; j++) begin
      r2_next = r2_next + (R2W'(hh2[j]) << 34) + (R2W'(hhl[j]) << 18) + R2W'(hl2[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pts3 <= pts2;
      r2   <= r2_next;
    end
  end

  assign bout.vld = v3;
  assign bout.pts = pts3;
  assign bout.r2  = r2;
  assign bout.sph = 1'b0;
  assign bout.cor = 1'b0;

endmodule

>>> rtl/fbc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_cell
// Tests the passing beat against one plane and folds in the hit flags.
// ----------------------------------------------------------------------------
module fbc_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic [63:0]    plane,
  input  logic           active,
  input  fbc_pkg::beat_t bin,
  output fbc_pkg::beat_t bout
);
  import fbc_pkg::*;

  logic signed [11:0]    nrm [3];
  logic signed [27:0]    dpl;
  logic signed [WW-1:0]  ws [NPTS][3];

  beat_t                 ra;
  beat_t                 rb;
  beat_t                 rc;
  beat_t                 rd;
  beat_t                 rd_next;
  logic signed [PRW-1:0] pa [NPTS][3];
  logic signed [DW-1:0]  dist_next [NPTS];
  logic signed [DW-1:0]  db [NPTS];

  logic                  pos_next;
  logic                  allout_next;
  logic [52:0]           mag;
  logic                  pos;
  logic                  allout;
  logic [51:0]           sq_hh;
  logic [52:0]           sq_hl;
  logic [53:0]           sq_ll;
  logic [SQW-1:0]        sq;
  logic [SQW-1:0]        lim;
  logic                  sph_hit;

  assign nrm[0] = plane[11:0];
  assign nrm[1] = plane[23:12];
  assign nrm[2] = plane[35:24];
  assign dpl    = plane[63:36];

  always_comb begin
    for (int p = 0; p < NPTS; p++) begin
      for (int c = 0; c < 3; c++) begin
        ws[p][c] = bin.pts[p][c];
      end
      dist_next[p] = DW'(pa[p][0]) + DW'(pa[p][1]) + DW'(pa[p][2]) + (DW'(dpl) <<< 12);
    end
  end

  always_comb begin
    rd_next     = rc;
    rd_next.sph = rc.sph | sph_hit;
    rd_next.cor = rc.cor | (allout & active);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ra.vld <= 1'b0;
      rb.vld <= 1'b0;
      rc.vld <= 1'b0;
      rd.vld <= 1'b0;
    end else if (adv) begin
      ra <= bin;
      rb <= ra;
      rc <= rb;
      rd <= rd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int p = 0; p < NPTS; p++) begin
        for (int c = 0; c < 3; c++) begin
          pa[p][c] <= PRW'(nrm[c]) * PRW'(ws[p][c]);
        end
        db[p] <= dist_next[p];
      end
    end
  end

  // centre sign and magnitude, corner sign check; centre distance squared in three partial products
  always_comb begin
    pos_next    = !db[CENTRE][DW-1] && (db[CENTRE] != '0);
    mag         = db[CENTRE][52:0];
    allout_next = 1'b1;
    for (int k = 0; k < 8; k++) begin
      allout_next = allout_next & !db[k][DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos    <= pos_next;
      allout <= allout_next;
      sq_hh  <= 52'(mag[52:27]) * 52'(mag[52:27]);
      sq_hl  <= 53'(mag[52:27]) * 53'(mag[26:0]);
      sq_ll  <= 54'(mag[26:0]) * 54'(mag[26:0]);
    end
  end

  assign sq      = (SQW'(sq_hh) << 54) + (SQW'(sq_hl) << 28) + SQW'(sq_ll);
  assign lim     = SQW'(rc.r2) << 22;
  assign sph_hit = active && pos && (sq > lim);

  assign bout = rd;

endmodule

>>> rtl/fbc_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_out
// Turns the hit flags into a reason and holds results in an output and skid pair.
// ----------------------------------------------------------------------------
module fbc_out (
  input  logic           clk,
  input  logic           rst,
  input  fbc_pkg::beat_t bin,
  input  logic [1:0]     mode,
  input  logic           out_stall,
  output logic           out_valid,
  output logic           culled,
  output logic [1:0]     cull_reason,
  output logic           full
);
  import fbc_pkg::*;

  logic       skid_vld;
  logic [1:0] skid_reason;
  logic [1:0] reason;
  logic       take;
  logic       out_free;

  always_comb begin
    if (mode == MODE_OFF) begin
      reason = REASON_KEEP;
    end else if (bin.sph) begin
      reason = REASON_SPHERE;
    end else if (mode[1] && bin.cor) begin
      reason = REASON_CORNER;
    end else begin
      reason = REASON_KEEP;
    end
  end

  assign take     = bin.vld && !skid_vld;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else if (out_free) begin
      if (skid_vld) begin
        out_valid <= 1'b1;
        skid_vld  <= 1'b0;
      end else begin
        out_valid <= take;
      end
    end else if (take) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      cull_reason <= skid_vld ? skid_reason : reason;
    end else if (take) begin
      skid_reason <= reason;
    end
  end

  assign culled = (cull_reason != REASON_KEEP);
  assign full   = skid_vld;

  // skid only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> out_valid)
    else $error("skid holds a beat with no result shown");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_vld && out_valid && out_stall |=> skid_vld)
    else $error("skid beat dropped under stall");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_vld && !out_stall |=> out_valid && !skid_vld)
    else $error("skid beat not moved to output");

  a_reason_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cull_reason == REASON_KEEP || cull_reason == REASON_SPHERE ||
                   cull_reason == REASON_CORNER))
    else $error("undefined cull reason");

endmodule
